// ===== rtl/swc_pkg.sv =====
package swc_pkg;

  localparam int unsigned NumDigits = 7;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned SegW      = 7;
  localparam int unsigned NumKeys   = 4;
  localparam int unsigned HourW     = 5;
  localparam int unsigned MinuteW   = 6;

  typedef logic [DigitW-1:0] bcd_t;
  typedef logic [SegW-1:0]   seg_t;

  typedef enum logic [1:0] {
    KeyW = 2'd0,
    KeyS = 2'd1,
    KeyE = 2'd2,
    KeyT = 2'd3
  } key_idx_e;

  typedef struct packed {
    logic en;
    logic clear;
    logic advance;
  } cnt_ctrl_t;

  typedef struct packed {
    bcd_t tens;
    bcd_t units;
  } bcd_pair_t;

  localparam bcd_t DigitMax [NumDigits] = '{
    4'd9, 4'd9, 4'd5, 4'd9, 4'd9, 4'd9, 4'd9
  };

  function automatic seg_t seg_of(bcd_t d);
    seg_t s;
    case (d)
      4'd0, 4'd10: s = 7'b1111110;
      4'd1, 4'd11: s = 7'b0110000;
      4'd2, 4'd12: s = 7'b1101101;
      4'd3, 4'd13: s = 7'b1111001;
      4'd4, 4'd14: s = 7'b0110011;
      4'd5, 4'd15: s = 7'b1011011;
      4'd6:        s = 7'b1011111;
      4'd7:        s = 7'b1110000;
      4'd8:        s = 7'b1111111;
      4'd9:        s = 7'b1111011;
      default:     s = 7'b1111110;
    endcase
    return s;
  endfunction

  function automatic bcd_pair_t split_dec(logic [MinuteW-1:0] v);
    bcd_pair_t p;
    logic [MinuteW-1:0] r;
    if (v >= 6'd60) begin
      p.tens = 4'd6;
      r      = v - 6'd60;
    end else if (v >= 6'd50) begin
      p.tens = 4'd5;
      r      = v - 6'd50;
    end else if (v >= 6'd40) begin
      p.tens = 4'd4;
      r      = v - 6'd40;
    end else if (v >= 6'd30) begin
      p.tens = 4'd3;
      r      = v - 6'd30;
    end else if (v >= 6'd20) begin
      p.tens = 4'd2;
      r      = v - 6'd20;
    end else if (v >= 6'd10) begin
      p.tens = 4'd1;
      r      = v - 6'd10;
    end else begin
      p.tens = 4'd0;
      r      = v;
    end
    p.units = r[DigitW-1:0];
    return p;
  endfunction

endpackage

// ===== rtl/swc_if.sv =====
interface swc_in_if;
  import swc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 key_w;
  logic                 key_s;
  logic                 key_e;
  logic                 key_t;
  logic                 tick;
  logic [HourW-1:0]     hour;
  logic [MinuteW-1:0]   minute;

  modport source (output valid, key_w, key_s, key_e, key_t, tick, hour, minute,
                  input ready);
  modport sink   (input valid, key_w, key_s, key_e, key_t, tick, hour, minute,
                  output ready);
endinterface

interface swc_out_if;
  import swc_pkg::*;
  logic             valid;
  logic             ready;
  logic [SegW-1:0]  digit0_segs;
  logic [SegW-1:0]  digit1_segs;
  logic [SegW-1:0]  digit2_segs;
  logic [SegW-1:0]  digit3_segs;
  logic [SegW-1:0]  msec_hundreds_segs;
  logic [SegW-1:0]  msec_tens_segs;
  logic [SegW-1:0]  msec_units_segs;
  logic             in_stopwatch;
  logic             is_running;

  modport source (output valid, digit0_segs, digit1_segs, digit2_segs, digit3_segs,
                  msec_hundreds_segs, msec_tens_segs, msec_units_segs,
                  in_stopwatch, is_running,
                  input ready);
  modport sink   (input valid, digit0_segs, digit1_segs, digit2_segs, digit3_segs,
                  msec_hundreds_segs, msec_tens_segs, msec_units_segs,
                  in_stopwatch, is_running,
                  output ready);
endinterface

// ===== rtl/swc_bcd_counter.sv =====
module swc_bcd_counter
  import swc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cnt_ctrl_t ctrl_i,
  output bcd_t      count_next_o [NumDigits]
);

  bcd_t digit_q [NumDigits];
  bcd_t digit_d [NumDigits];
  bcd_t base    [NumDigits];

  always_comb begin
    logic at_max;
    logic carry;
    at_max = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      base[i] = ctrl_i.clear ? '0 : digit_q[i];
      if (base[i] != DigitMax[i]) begin
        at_max = 1'b0;
      end
    end
    carry = ctrl_i.advance && !at_max;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      digit_d[i] = base[i];
      if (carry) begin
        if (base[i] >= DigitMax[i]) begin
          digit_d[i] = '0;
        end else begin
          digit_d[i] = base[i] + 4'd1;
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        digit_q[i] <= '0;
      end
    end else if (ctrl_i.en) begin
      digit_q <= digit_d;
    end
  end

  assign count_next_o = digit_d;

`ifndef SYNTHESIS
  a_sec_tens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q[2] <= DigitMax[2])
    else $error("second tens digit out of range");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.en && ctrl_i.clear && !ctrl_i.advance |=>
      digit_q[0] == '0 && digit_q[3] == '0 && digit_q[6] == '0)
    else $error("count not cleared");
`endif

endmodule

// ===== rtl/stopwatch_clock_seven_segment_unit.sv =====
// Stopwatch and time-of-day driver for a seven-digit seven-segment display.
// Input channel in_i: one sample per transaction with four key levels
// (W, S, E, T), a millisecond tick and the time of day (hour, minute).
// Key presses are rising edges against the previous sample. W enters
// stopwatch mode and clears the count, S starts, E pauses, T returns to
// clock mode. Output channel out_o: one transaction per sample with seven
// segment patterns (bit 6 top segment) plus mode and running flags.
// Clock mode shows HH:MM with the millisecond digits blank; stopwatch mode
// shows MM:SS and three millisecond digits, saturating at 99:59.999.
// Timing: a sample accepted by in_i is registered in the input stage, and its
// result is loaded into the output register, raising out_o.valid, once the
// output register is empty or its result is being taken by the receiver.
// Throughput: one transaction per cycle unless the receiver stalls; the edge
// detect, BCD increment and segment decode are combinational between stages.
// Reset clears the key history, selects clock mode, stops and zeroes the
// count, and empties both stages.
// When the receiver stalls, the output register holds and the input stage
// still takes one more sample; in_i.ready drops only when both are full.
module stopwatch_clock_seven_segment_unit
  import swc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  swc_in_if.sink    in_i,
  swc_out_if.source out_o
);

  logic               s1_valid_q;
  logic               s1_adv;
  logic               in_fire;
  logic               s1_fire;
  logic [NumKeys-1:0] s1_keys_q;
  logic               s1_tick_q;
  logic [HourW-1:0]   s1_hour_q;
  logic [MinuteW-1:0] s1_minute_q;

  logic [NumKeys-1:0] prev_keys_q;
  logic               mode_q, mode_d;
  logic               counting_q, counting_d;
  logic [NumKeys-1:0] rise;
  cnt_ctrl_t          cnt_ctrl;
  bcd_t               cnt_next [NumDigits];

  bcd_pair_t          hour_dec;
  bcd_pair_t          minute_dec;
  seg_t               segs_d [NumDigits];

  logic               out_valid_q;
  seg_t               segs_q [NumDigits];
  logic               out_mode_q;
  logic               out_run_q;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign s1_fire    = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_keys_q   <= {in_i.key_t, in_i.key_e, in_i.key_s, in_i.key_w};
      s1_tick_q   <= in_i.tick;
      s1_hour_q   <= in_i.hour;
      s1_minute_q <= in_i.minute;
    end
  end

  always_comb begin
    rise       = s1_keys_q & ~prev_keys_q;
    mode_d     = mode_q;
    counting_d = counting_q;
    cnt_ctrl   = '0;
    if (rise[KeyW]) begin
      mode_d         = 1'b1;
      counting_d     = 1'b0;
      cnt_ctrl.clear = 1'b1;
    end
    if (mode_d && rise[KeyS]) begin
      counting_d = 1'b1;
    end
    if (mode_d && rise[KeyE]) begin
      counting_d = 1'b0;
    end
    if (mode_d && rise[KeyT]) begin
      mode_d = 1'b0;
    end
    cnt_ctrl.advance = counting_d && s1_tick_q;
    cnt_ctrl.en      = s1_fire;
  end

  swc_bcd_counter u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (cnt_ctrl),
    .count_next_o (cnt_next)
  );

  always_comb begin
    hour_dec   = split_dec({1'b0, s1_hour_q});
    minute_dec = split_dec(s1_minute_q);
    if (mode_d) begin
      for (int i = 0; i < NumDigits; i++) begin
        segs_d[i] = seg_of(cnt_next[i]);
      end
    end else begin
      segs_d[0] = seg_of(hour_dec.tens);
      segs_d[1] = seg_of(hour_dec.units);
      segs_d[2] = seg_of(minute_dec.tens);
      segs_d[3] = seg_of(minute_dec.units);
      for (int i = 4; i < NumDigits; i++) begin
        segs_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q <= '0;
      mode_q      <= 1'b0;
      counting_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        prev_keys_q <= s1_keys_q;
        mode_q      <= mode_d;
        counting_q  <= counting_d;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      segs_q     <= segs_d;
      out_mode_q <= mode_d;
      out_run_q  <= counting_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.digit0_segs        = segs_q[0];
  assign out_o.digit1_segs        = segs_q[1];
  assign out_o.digit2_segs        = segs_q[2];
  assign out_o.digit3_segs        = segs_q[3];
  assign out_o.msec_hundreds_segs = segs_q[4];
  assign out_o.msec_tens_segs     = segs_q[5];
  assign out_o.msec_units_segs    = segs_q[6];
  assign out_o.in_stopwatch       = out_mode_q;
  assign out_o.is_running         = out_run_q;

`ifndef SYNTHESIS
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed sample produced no result");

  a_clock_blank_msec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_mode_q |->
      segs_q[4] == '0 && segs_q[5] == '0 && segs_q[6] == '0)
    else $error("millisecond digits lit in clock mode");

  a_w_enters_stopwatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && rise[KeyW] && !rise[KeyT] |=> mode_q)
    else $error("W press did not enter stopwatch mode");

  a_no_start_in_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !mode_q && !rise[KeyW] |=> counting_q == $past(counting_q))
    else $error("running state changed in clock mode");
`endif

endmodule
